### rtl/rrsd_pkg.sv
// Shared types and constants for the round-robin slice dispatcher.
`timescale 1ns / 1ps

package rrsd_pkg;

  localparam int OPCODE_W     = 2;
  localparam int BURST_W      = 16;
  localparam int QUANTUM_W    = 8;
  localparam int TASK_INDEX_W = 6;
  localparam int SLICE_W      = 8;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

  // Result of the shared slice unit for one table entry.
  typedef struct packed {
    logic               busy;      // entry still has time left
    logic [SLICE_W-1:0] slice;     // min(quantum, remaining), zero quantum as one
    logic [BURST_W-1:0] rem_next;  // remaining minus slice
  } slice_res_t;

endpackage

### rtl/rrsd_if.sv
// Valid/ready channel interfaces for dispatcher items and results.
`timescale 1ns / 1ps

interface rrsd_in_if;
  import rrsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BURST_W-1:0]  burst_length;

  modport source (output valid, output opcode, output burst_length, input ready);
  modport sink   (input valid, input opcode, input burst_length, output ready);
endinterface

interface rrsd_out_if;
  import rrsd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TASK_INDEX_W-1:0] task_index;
  logic [SLICE_W-1:0]      slice_length;
  logic                    all_done;

  modport source (output valid, output task_index, output slice_length, output all_done,
                  input ready);
  modport sink   (input valid, input task_index, input slice_length, input all_done,
                  output ready);
endinterface

### rtl/rrsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/rrsd_slice_unit.sv
// Shared compare/subtract unit: slice grant and remaining-time update.
`timescale 1ns / 1ps

module rrsd_slice_unit (
  input  logic [rrsd_pkg::BURST_W-1:0]   rem_i,
  input  logic [rrsd_pkg::QUANTUM_W-1:0] quantum_i,
  output rrsd_pkg::slice_res_t           res_o
);
  import rrsd_pkg::*;

  logic [QUANTUM_W-1:0] q_eff;
  logic [BURST_W-1:0]   q_wide;
  logic [BURST_W-1:0]   slice_wide;

  // A zero quantum acts as one.
  assign q_eff      = (quantum_i == '0) ? QUANTUM_W'(1) : quantum_i;
  assign q_wide     = BURST_W'(q_eff);
  assign slice_wide = (rem_i < q_wide) ? rem_i : q_wide;

  assign res_o.busy     = (rem_i != '0);
  assign res_o.slice    = slice_wide[SLICE_W-1:0];
  assign res_o.rem_next = rem_i - slice_wide;

endmodule

### rtl/round_robin_slice_dispatcher.sv
// Top level of the round-robin time-slice dispatcher.
//
//   channel   dir   handshake             payload
//   in_i      in    valid/ready           opcode, burst_length
//   out_o     out   valid/ready           task_index, slice_length, all_done
//   cfg       in    cfg_we_i (no ready)   cfg_wdata_i -> quantum
//
// Add and clear items are handled in S_IDLE. A dispatch walks the table from
// the slot after the last task served: S_READ reads each slot from the RAM,
// S_CHECK checks it through the shared slice unit. A hit is handed off from
// S_CHECK; an empty or all-finished table ends in S_FINISH with all_done. The
// registered RAM read sets the pace. Reset clears task count, search start and
// handshake state and sets the quantum to QUANTUM_RESET; the RAM holds no
// reset value. The output register lets the next item in while a result
// waits; a dispatch that finds its answer holds until it is free.
`timescale 1ns / 1ps

module round_robin_slice_dispatcher #(
  parameter int MAX_TASKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrsd_pkg::QUANTUM_W-1:0] cfg_wdata_i,
  rrsd_in_if.sink                       in_i,
  rrsd_out_if.source                    out_o
);
  import rrsd_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;       // slot under examination
  logic [CNT_W-1:0]     k_q, k_d;           // slots examined so far
  logic [CNT_W-1:0]     count_q, count_d;   // loaded tasks
  logic [IDX_W-1:0]     next_q, next_d;     // where the next search starts
  logic [QUANTUM_W-1:0] quantum_q;

  logic                    out_valid_q, out_valid_d;
  logic [TASK_INDEX_W-1:0] out_index_q, out_index_d;
  logic [SLICE_W-1:0]      out_slice_q, out_slice_d;
  logic                    out_done_q, out_done_d;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  table_full;
  logic [CNT_W-1:0]      idx_plus1;
  logic [CNT_W-1:0]      k_plus1;
  logic [IDX_W-1:0]      start_slot;
  logic [IDX_W+TASK_INDEX_W-1:0] idx_wide;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [BURST_W-1:0]    ram_wdata;
  logic [BURST_W-1:0]    ram_rdata;
  slice_res_t            slice_res;

  rrsd_ram #(
    .WIDTH (BURST_W),
    .DEPTH (MAX_TASKS)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  rrsd_slice_unit u_slice (
    .rem_i     (ram_rdata),
    .quantum_i (quantum_q),
    .res_o     (slice_res)
  );

  // Accept items only between dispatches.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign table_full = (count_q >= CNT_W'(MAX_TASKS));
  assign idx_plus1  = CNT_W'(idx_q) + CNT_W'(1);
  assign k_plus1    = k_q + CNT_W'(1);
  assign start_slot = (CNT_W'(next_q) < count_q) ? next_q : '0;
  // Report the slot masked to the result field's width.
  assign idx_wide   = {{TASK_INDEX_W{1'b0}}, idx_q};

  // One write port: appends from idle, updates from the check step.
  always_comb begin
    if (state_q == S_CHECK) begin
      ram_we    = slice_res.busy && out_free;
      ram_waddr = idx_q;
      ram_wdata = slice_res.rem_next;
    end else begin
      ram_we    = in_fire && (in_i.opcode == OP_ADD) && !table_full;
      ram_waddr = count_q[IDX_W-1:0];
      ram_wdata = in_i.burst_length;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    count_d     = count_q;
    next_d      = next_q;
    out_load    = 1'b0;
    out_index_d = out_index_q;
    out_slice_d = out_slice_q;
    out_done_d  = out_done_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.opcode)
            OP_ADD: begin
              // Drop the task when the table is full.
              if (!table_full) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              next_d  = '0;
            end
            OP_DISPATCH: begin
              idx_d = start_slot;
              k_d   = '0;
              if (count_q == '0) begin
                state_d = S_FINISH;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              // Unused opcode: no effect, no result.
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (slice_res.busy) begin
          // Hold on the hit until the output register frees up.
          if (out_free) begin
            out_load    = 1'b1;
            out_index_d = idx_wide[TASK_INDEX_W-1:0];
            out_slice_d = slice_res.slice;
            out_done_d  = 1'b0;
            next_d      = (idx_plus1 == CNT_W'(MAX_TASKS)) ? '0 : idx_plus1[IDX_W-1:0];
            state_d     = S_IDLE;
          end
        end else if (k_plus1 == count_q) begin
          state_d = S_FINISH;
        end else begin
          // Skip a finished task, wrap at the last loaded slot.
          k_d     = k_plus1;
          idx_d   = (idx_plus1 == count_q) ? '0 : idx_plus1[IDX_W-1:0];
          state_d = S_READ;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_index_d = '0;
          out_slice_d = '0;
          out_done_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      count_q     <= '0;
      next_q      <= '0;
      quantum_q   <= QUANTUM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      count_q     <= count_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_slice_q <= out_slice_d;
    out_done_q  <= out_done_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.task_index   = out_index_q;
  assign out_o.slice_length = out_slice_q;
  assign out_o.all_done     = out_done_q;

endmodule
